// ----- rtl/query_string_pair_decoder_top_assert.svh -----
// Assertion macros of the query string pair decoder RTL.
`ifndef QUERY_STRING_PAIR_DECODER_TOP_ASSERT_SVH
`define QUERY_STRING_PAIR_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define QSPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qspd assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define QSPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qspd assertion failed");

`endif

// ----- rtl/qspd_pkg.sv -----
// Package with types, codes and the hex digit decoder of the query string pair decoder.
package qspd_pkg;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE   = 3'd0,
    KIND_VALUE_BYTE = 3'd1,
    KIND_KEY_DONE   = 3'd2,
    KIND_PAIR_DONE  = 3'd3,
    KIND_DISCARD    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ESC_IDLE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_t;

  localparam logic [1:0] CFG_KV_SEP   = 2'd0;
  localparam logic [1:0] CFG_PAIR_SEP = 2'd1;
  localparam logic [1:0] CFG_ESCAPE   = 2'd2;

  localparam logic [7:0] KV_SEP_RESET   = 8'd61;
  localparam logic [7:0] PAIR_SEP_RESET = 8'd38;
  localparam logic [7:0] ESCAPE_RESET   = 8'd37;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CountW    = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       eos;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } hex_t;

  // Maps an ASCII hex digit of either case to its value; anything else is bad.
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad    = 1'b0;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.nibble = 4'(c - 8'h61 + 8'd10);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.nibble = 4'(c - 8'h41 + 8'd10);
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

// ----- rtl/query_string_pair_decoder_top.sv -----
// Top level of the query string pair decoder: parser state, result queue and ports.
//
//   Channel   Direction  Handshake                   Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata = in_byte, tlast = final_byte
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata = out_byte, tuser = kind, eos,
//                                                     tlast = last_in_run
//   cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// The decoder takes one byte per cycle while s_axis_tready is high. Each byte is parsed
// in the cycle it is accepted and its results (none, one or two) are written into a
// four-entry result queue, so they are registered before they are offered.
// The output drains one result per cycle while m_axis_tready is high; only a final
// byte can add two, and s_axis_tready drops while fewer than two queue entries are free.
// A synchronous reset returns the parser to the key state, empties the queue
// and loads the separator and escape registers with '=', '&' and '%'.
// Configuration writes are always taken and should arrive while the block is idle.
module query_string_pair_decoder_top
  import qspd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // final_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [3:0] m_axis_tuser,   // [2:0] kind, [3] end_of_stream
  output logic       m_axis_tlast,   // last_in_run
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

`include "query_string_pair_decoder_top_assert.svh"

  // Configuration registers.
  logic [7:0] kv_sep;
  logic [7:0] pair_sep;
  logic [7:0] escape_mark;

  // Parser state.
  logic       in_value;
  esc_t       esc_stage;
  logic [3:0] high_nibble;
  logic       part_failed;

  logic       in_value_next;
  esc_t       esc_stage_next;
  logic [3:0] high_nibble_next;
  logic       part_failed_next;

  // Result queue.
  res_t              fifo [FifoDepth];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CountW-1:0] count;

  logic       s_fire;
  logic       m_fire;
  logic [1:0] push_cnt;
  res_t       res_a;
  res_t       res_b;

  // Scratch values of the parse.
  logic [7:0] sep;
  hex_t       hex;
  logic       data_hit;
  res_t       data_res;
  res_t       fin_res;
  kind_t      data_kind;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (count <= CountW'(FifoDepth - 2));
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  assign m_axis_tvalid = (count != '0);
  assign m_axis_tdata  = fifo[rd_ptr].data;
  assign m_axis_tuser  = {fifo[rd_ptr].eos, fifo[rd_ptr].kind};
  assign m_axis_tlast  = fifo[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      kv_sep      <= KV_SEP_RESET;
      pair_sep    <= PAIR_SEP_RESET;
      escape_mark <= ESCAPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_KV_SEP:   kv_sep      <= cfg_data;
        CFG_PAIR_SEP: pair_sep    <= cfg_data;
        CFG_ESCAPE:   escape_mark <= cfg_data;
        default: ;  // Indexes beyond the register list are ignored.
      endcase
    end
  end

  // One pass over the incoming byte: the separator of the current part wins
  // over everything, then the escape sequencer, then the final-byte closer.
  always_comb begin
    in_value_next    = in_value;
    esc_stage_next   = esc_stage;
    high_nibble_next = high_nibble;
    part_failed_next = part_failed;

    sep       = in_value ? pair_sep : kv_sep;
    hex       = hex_decode(s_axis_tdata);
    data_kind = in_value ? KIND_VALUE_BYTE : KIND_KEY_BYTE;
    data_hit  = 1'b0;

    data_res.data = 8'd0;
    data_res.kind = data_kind;
    data_res.eos  = 1'b0;
    data_res.last = 1'b0;

    if (s_axis_tdata == sep) begin
      // The separator closes the part even inside an escape or after an error.
      data_hit         = 1'b1;
      data_res.kind    = in_value ? KIND_PAIR_DONE : KIND_KEY_DONE;
      in_value_next    = !in_value;
      esc_stage_next   = ESC_IDLE;
      high_nibble_next = 4'd0;
      part_failed_next = 1'b0;
    end else if (!part_failed) begin
      case (esc_stage)
        ESC_IDLE: begin
          if (s_axis_tdata == escape_mark) begin
            esc_stage_next = ESC_HIGH;
          end else begin
            data_hit      = 1'b1;
            data_res.data = s_axis_tdata;
          end
        end
        ESC_HIGH: begin
          if (hex.bad) begin
            part_failed_next = 1'b1;
            esc_stage_next   = ESC_IDLE;
            high_nibble_next = 4'd0;
          end else begin
            high_nibble_next = hex.nibble;
            esc_stage_next   = ESC_LOW;
          end
        end
        default: begin
          if (hex.bad) begin
            part_failed_next = 1'b1;
          end else begin
            data_hit      = 1'b1;
            data_res.data = {high_nibble, hex.nibble};
          end
          esc_stage_next   = ESC_IDLE;
          high_nibble_next = 4'd0;
        end
      endcase
    end

    // The closing result looks at the part as it stands after this byte.
    fin_res.data = 8'd0;
    fin_res.kind = in_value_next ? KIND_PAIR_DONE : KIND_DISCARD;
    fin_res.eos  = 1'b1;
    fin_res.last = 1'b1;

    if (s_axis_tlast) begin
      in_value_next    = 1'b0;
      esc_stage_next   = ESC_IDLE;
      high_nibble_next = 4'd0;
      part_failed_next = 1'b0;
    end

    // Pack the results into the first free slots.
    data_res.last = !s_axis_tlast;
    if (data_hit) begin
      res_a    = data_res;
      res_b    = fin_res;
      push_cnt = s_axis_tlast ? 2'd2 : 2'd1;
    end else begin
      res_a    = fin_res;
      res_b    = fin_res;
      push_cnt = s_axis_tlast ? 2'd1 : 2'd0;
    end
    if (!s_fire) begin
      push_cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_value    <= 1'b0;
      esc_stage   <= ESC_IDLE;
      high_nibble <= 4'd0;
      part_failed <= 1'b0;
    end else if (s_fire) begin
      in_value    <= in_value_next;
      esc_stage   <= esc_stage_next;
      high_nibble <= high_nibble_next;
      part_failed <= part_failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      fifo[wr_ptr] <= res_a;
    end
    if (push_cnt == 2'd2) begin
      fifo[wr_ptr + PtrW'(1)] <= res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push_cnt);
      if (m_fire) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + CountW'(push_cnt) - CountW'(m_fire);
    end
  end

  // The queue never holds more results than it has entries.
  `QSPD_ASSERT_NOW(a_queue_bound, 1'b1, count <= CountW'(FifoDepth))
  // A final byte leaves the parser in its reset state.
  `QSPD_ASSERT_NEXT(a_final_clears, s_fire && s_axis_tlast,
                    !in_value && esc_stage == ESC_IDLE && !part_failed && high_nibble == 4'd0)
  // A failed part never keeps an escape open.
  `QSPD_ASSERT_NOW(a_fail_no_escape, part_failed, esc_stage == ESC_IDLE)
  // A drained result with nothing pushed shrinks the queue by exactly one.
  `QSPD_ASSERT_NEXT(a_pop_only, m_fire && push_cnt == 2'd0, count == $past(count) - CountW'(1))
  // A closing result always ends the run of its byte.
  `QSPD_ASSERT_NOW(a_eos_last, m_axis_tvalid && m_axis_tuser[3], m_axis_tlast)

endmodule
